// ----- hdl/dependency_aware_task_scheduler_defines.svh -----
// assertion macros shared by the checker
`ifndef DEPENDENCY_AWARE_TASK_SCHEDULER_DEFINES_SVH
`define DEPENDENCY_AWARE_TASK_SCHEDULER_DEFINES_SVH

// same-cycle implication, checked outside reset
`define DATS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("dats check failed");

// next-cycle implication, checked outside reset
`define DATS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("dats check failed");

`endif

// ----- hdl/dats_pkg.sv -----
`timescale 1ns / 1ps
package dats_pkg;

  localparam int POOL_DEPTH = 512;
  localparam int IDX_W = $clog2(POOL_DEPTH);
  localparam int CNT_W = $clog2(POOL_DEPTH + 1);
  localparam int JOB_W = 10;

  // commands
  localparam logic [2:0] CMD_ADD = 3'd0;
  localparam logic [2:0] CMD_END = 3'd1;
  localparam logic [2:0] CMD_POP = 3'd2;
  localparam logic [2:0] CMD_DONE = 3'd3;
  localparam logic [2:0] CMD_QUERY = 3'd4;

  // status codes
  localparam logic [1:0] STAT_OK = 2'd0;
  localparam logic [1:0] STAT_FULL = 2'd1;
  localparam logic [1:0] STAT_EMPTY = 2'd2;

  // cell operations
  localparam logic [2:0] CELL_NOP = 3'd0;
  localparam logic [2:0] CELL_INSERT = 3'd1;
  localparam logic [2:0] CELL_JOB_ADJ = 3'd2;
  localparam logic [2:0] CELL_REMOVE = 3'd3;
  localparam logic [2:0] CELL_UNQUEUE = 3'd4;
  localparam logic [2:0] CELL_ROT_LOAD = 3'd5;
  localparam logic [2:0] CELL_ROT_STEP = 3'd6;

  typedef struct packed {
    logic [2:0]  command;
    logic [15:0] priority_req;
    logic [31:0] depend_id;
    logic [31:0] parent_id;
    logic [31:0] task_id;
    logic [31:0] work_handle;
    logic [31:0] work_argument;
    logic        batch_last;
  } in_word_t;

  typedef struct packed {
    logic [31:0] result_id;
    logic [31:0] out_handle;
    logic [31:0] out_argument;
    logic        is_done;
    logic [1:0]  status;
  } out_word_t;

  typedef struct packed {
    logic [31:0]      id;
    logic [31:0]      depend;
    logic [31:0]      parent;
    logic [15:0]      prio;
    logic [JOB_W-1:0] jobs;
    logic [31:0]      handle;
    logic [31:0]      argument;
  } task_t;

  typedef struct packed {
    logic  occ;
    logic  queued;
    task_t data;
  } cell_link_t;

  typedef struct packed {
    logic [2:0]       op;
    logic             dec;
    logic [31:0]      key;
    logic [IDX_W-1:0] sel;
    task_t            new_task;
  } cell_ctl_t;

endpackage

// ----- hdl/dats_cell.sv -----
`timescale 1ns / 1ps
module dats_cell (
  input  logic                    clk,
  input  logic                    rst_n,
  input  dats_pkg::cell_ctl_t     ctl,
  input  logic [dats_pkg::IDX_W-1:0] cell_idx,
  input  dats_pkg::cell_link_t    prev_link,
  input  logic                    prev_ins,
  input  dats_pkg::cell_link_t    next_link,
  input  logic [31:0]             rot_in,
  output dats_pkg::cell_link_t    link,
  output logic                    ins_out,
  output logic [31:0]             rot_out,
  output logic                    cand
);
  import dats_pkg::*;

  logic       occ_r, occ_nxt;
  logic       queued_r, queued_nxt;
  logic       blocked_r, blocked_nxt;
  task_t      data_r, data_nxt;
  logic [31:0] rot_r, rot_nxt;

  // sorted insert: new word goes in front of the first higher priority
  assign ins_out = !occ_r || (data_r.prio > ctl.new_task.prio);

  assign link = '{occ: occ_r, queued: queued_r, data: data_r};
  assign rot_out = rot_r;
  assign cand = occ_r && queued_r && (data_r.jobs == JOB_W'(1)) && !blocked_r;

  // per-cell update
  always_comb begin
    occ_nxt = occ_r;
    queued_nxt = queued_r;
    blocked_nxt = blocked_r;
    data_nxt = data_r;
    rot_nxt = rot_r;
    case (ctl.op)
      CELL_INSERT: begin
        if (ins_out) begin
          if (prev_ins) begin
            occ_nxt = prev_link.occ;
            queued_nxt = prev_link.queued;
            data_nxt = prev_link.data;
          end else begin
            occ_nxt = 1'b1;
            queued_nxt = 1'b1;
            data_nxt = ctl.new_task;
          end
        end
      end
      CELL_JOB_ADJ: begin
        if (occ_r && data_r.id == ctl.key) begin
          data_nxt.jobs = ctl.dec ? data_r.jobs - JOB_W'(1) : data_r.jobs + JOB_W'(1);
        end
      end
      CELL_REMOVE: begin
        if (cell_idx >= ctl.sel) begin
          occ_nxt = next_link.occ;
          queued_nxt = next_link.queued;
          data_nxt = next_link.data;
        end
      end
      CELL_UNQUEUE: begin
        if (cell_idx == ctl.sel) begin
          queued_nxt = 1'b0;
        end
      end
      CELL_ROT_LOAD: begin
        rot_nxt = occ_r ? data_r.id : 32'd0;
        blocked_nxt = 1'b0;
      end
      CELL_ROT_STEP: begin
        // open ids circulate around the ring past every dependency
        if (data_r.depend != 32'd0 && rot_r == data_r.depend) begin
          blocked_nxt = 1'b1;
        end
        rot_nxt = rot_in;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= 1'b0;
      queued_r <= 1'b0;
    end else begin
      occ_r <= occ_nxt;
      queued_r <= queued_nxt;
    end
    blocked_r <= blocked_nxt;
    data_r <= data_nxt;
    rot_r <= rot_nxt;
  end

endmodule

// ----- hdl/dependency_aware_task_scheduler.sv -----
`timescale 1ns / 1ps
// task scheduler on a sorted row of pool cells, one word in flight at a time
// pop: id rotation around the cell ring, then a scan from the highest priority down
// full/empty cases answer straight from idle; one result strobe per word, receiver cannot stall
// synchronous active-low reset empties the pool and clears the id counter at once
module dependency_aware_task_scheduler (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  dats_pkg::in_word_t  in_word,
  output logic                out_strobe,
  output dats_pkg::out_word_t out_word
);
  import dats_pkg::*;

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_ADD_PAR = 4'd1;
  localparam logic [3:0] ST_ADD_INS = 4'd2;
  localparam logic [3:0] ST_END = 4'd3;
  localparam logic [3:0] ST_ROT_LOAD = 4'd4;
  localparam logic [3:0] ST_ROT = 4'd5;
  localparam logic [3:0] ST_POP_SCAN = 4'd6;
  localparam logic [3:0] ST_POP_UNQ = 4'd7;
  localparam logic [3:0] ST_FIND_SCAN = 4'd8;
  localparam logic [3:0] ST_REMOVE = 4'd9;
  localparam logic [3:0] ST_PAR_DEC = 4'd10;

  logic [3:0]       state_r, state_nxt;
  in_word_t         in_r, in_nxt;
  logic [IDX_W-1:0] ptr_r, ptr_nxt;
  logic [CNT_W-1:0] rot_cnt_r, rot_cnt_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [31:0]      idc_r, idc_nxt;
  logic [31:0]      par_r, par_nxt;
  out_word_t        out_r, out_nxt;
  logic             strobe_r, strobe_nxt;

  cell_ctl_t  ctl;
  cell_link_t link_w [POOL_DEPTH];
  logic       ins_w [POOL_DEPTH];
  logic [31:0] rot_w [POOL_DEPTH];
  logic       cand_w [POOL_DEPTH];
  logic [31:0] next_id;
  logic       scan_hit;
  logic       scan_last;

  // the cell row
  for (genvar i = 0; i < POOL_DEPTH; i++) begin : g_cell
    dats_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (ctl),
      .cell_idx  (IDX_W'(i)),
      .prev_link ((i == 0) ? cell_link_t'('0) : link_w[(i + POOL_DEPTH - 1) % POOL_DEPTH]),
      .prev_ins  ((i == 0) ? 1'b0 : ins_w[(i + POOL_DEPTH - 1) % POOL_DEPTH]),
      .next_link ((i == POOL_DEPTH - 1) ? cell_link_t'('0) : link_w[(i + 1) % POOL_DEPTH]),
      .rot_in    (rot_w[(i + POOL_DEPTH - 1) % POOL_DEPTH]),
      .link      (link_w[i]),
      .ins_out   (ins_w[i]),
      .rot_out   (rot_w[i]),
      .cand      (cand_w[i])
    );
  end

  // fresh id, skipping zero
  assign next_id = (idc_r + 32'd1 == 32'd0) ? 32'd1 : idc_r + 32'd1;
  assign scan_hit = (link_w[ptr_r].data.id == in_r.task_id);
  assign scan_last = ({1'b0, ptr_r} + CNT_W'(1)) == count_r;

  assign busy = (state_r != ST_IDLE);
  assign out_strobe = strobe_r;
  assign out_word = out_r;

  // broadcast control to the cells
  always_comb begin
    ctl.op = CELL_NOP;
    ctl.dec = 1'b0;
    ctl.key = 32'd0;
    ctl.sel = ptr_r;
    ctl.new_task.id = next_id;
    ctl.new_task.depend = in_r.depend_id;
    ctl.new_task.parent = in_r.parent_id;
    ctl.new_task.prio = in_r.priority_req;
    // a task named as its own parent holds one job more
    ctl.new_task.jobs = (in_r.parent_id == next_id) ? JOB_W'(3) : JOB_W'(2);
    ctl.new_task.handle = in_r.work_handle;
    ctl.new_task.argument = in_r.work_argument;
    case (state_r)
      ST_ADD_PAR: begin
        ctl.key = in_r.parent_id;
        if (in_r.parent_id != 32'd0) ctl.op = CELL_JOB_ADJ;
      end
      ST_ADD_INS: ctl.op = CELL_INSERT;
      ST_END: begin
        ctl.key = in_r.task_id;
        ctl.dec = 1'b1;
        if (in_r.task_id != 32'd0) ctl.op = CELL_JOB_ADJ;
      end
      ST_ROT_LOAD: ctl.op = CELL_ROT_LOAD;
      ST_ROT: ctl.op = CELL_ROT_STEP;
      ST_POP_UNQ: ctl.op = CELL_UNQUEUE;
      ST_REMOVE: ctl.op = CELL_REMOVE;
      ST_PAR_DEC: begin
        ctl.key = par_r;
        ctl.dec = 1'b1;
        if (par_r != 32'd0) ctl.op = CELL_JOB_ADJ;
      end
      default: begin
      end
    endcase
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    in_nxt = in_r;
    ptr_nxt = ptr_r;
    rot_cnt_nxt = rot_cnt_r;
    count_nxt = count_r;
    idc_nxt = idc_r;
    par_nxt = par_r;
    out_nxt = out_r;
    strobe_nxt = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          in_nxt = in_word;
          case (in_word.command)
            CMD_ADD: begin
              if (count_r == CNT_W'(POOL_DEPTH)) begin
                out_nxt = '0;
                out_nxt.status = STAT_FULL;
                strobe_nxt = 1'b1;
              end else begin
                state_nxt = ST_ADD_PAR;
              end
            end
            CMD_END: state_nxt = ST_END;
            CMD_POP: begin
              if (count_r == '0) begin
                out_nxt = '0;
                out_nxt.status = STAT_EMPTY;
                strobe_nxt = 1'b1;
              end else begin
                state_nxt = ST_ROT_LOAD;
              end
            end
            CMD_DONE, CMD_QUERY: begin
              if (count_r == '0) begin
                out_nxt = '0;
                out_nxt.is_done = (in_word.command == CMD_QUERY);
                strobe_nxt = 1'b1;
              end else begin
                ptr_nxt = '0;
                state_nxt = ST_FIND_SCAN;
              end
            end
            default: begin
              out_nxt = '0;
              strobe_nxt = 1'b1;
            end
          endcase
        end
      end
      ST_ADD_PAR: state_nxt = ST_ADD_INS;
      ST_ADD_INS: begin
        count_nxt = count_r + CNT_W'(1);
        idc_nxt = next_id;
        out_nxt = '0;
        out_nxt.result_id = next_id;
        strobe_nxt = 1'b1;
        state_nxt = ST_IDLE;
      end
      ST_END: begin
        out_nxt = '0;
        strobe_nxt = 1'b1;
        state_nxt = ST_IDLE;
      end
      ST_ROT_LOAD: begin
        rot_cnt_nxt = '0;
        state_nxt = ST_ROT;
      end
      ST_ROT: begin
        rot_cnt_nxt = rot_cnt_r + CNT_W'(1);
        if (rot_cnt_r == CNT_W'(POOL_DEPTH - 1)) begin
          ptr_nxt = IDX_W'(count_r - CNT_W'(1));
          state_nxt = ST_POP_SCAN;
        end
      end
      // from the highest priority down
      ST_POP_SCAN: begin
        if (cand_w[ptr_r]) begin
          out_nxt = '0;
          out_nxt.result_id = link_w[ptr_r].data.id;
          out_nxt.out_handle = link_w[ptr_r].data.handle;
          out_nxt.out_argument = link_w[ptr_r].data.argument;
          state_nxt = ST_POP_UNQ;
        end else if (ptr_r == '0) begin
          out_nxt = '0;
          out_nxt.status = STAT_EMPTY;
          strobe_nxt = 1'b1;
          state_nxt = ST_IDLE;
        end else begin
          ptr_nxt = ptr_r - IDX_W'(1);
        end
      end
      ST_POP_UNQ: begin
        strobe_nxt = 1'b1;
        state_nxt = ST_IDLE;
      end
      // id search for done and query
      ST_FIND_SCAN: begin
        if (scan_hit) begin
          if (in_r.command == CMD_QUERY) begin
            out_nxt = '0;
            strobe_nxt = 1'b1;
            state_nxt = ST_IDLE;
          end else begin
            par_nxt = link_w[ptr_r].data.parent;
            state_nxt = ST_REMOVE;
          end
        end else if (scan_last) begin
          out_nxt = '0;
          out_nxt.is_done = (in_r.command == CMD_QUERY);
          strobe_nxt = 1'b1;
          state_nxt = ST_IDLE;
        end else begin
          ptr_nxt = ptr_r + IDX_W'(1);
        end
      end
      ST_REMOVE: begin
        count_nxt = count_r - CNT_W'(1);
        state_nxt = ST_PAR_DEC;
      end
      ST_PAR_DEC: begin
        out_nxt = '0;
        strobe_nxt = 1'b1;
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      count_r <= '0;
      idc_r <= 32'd0;
      strobe_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      idc_r <= idc_nxt;
      strobe_r <= strobe_nxt;
    end
    in_r <= in_nxt;
    ptr_r <= ptr_nxt;
    rot_cnt_r <= rot_cnt_nxt;
    par_r <= par_nxt;
    out_r <= out_nxt;
  end

endmodule

// ----- hdl/dats_checker.sv -----
`timescale 1ns / 1ps
`include "dependency_aware_task_scheduler_defines.svh"
module dats_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                start,
  input logic                busy,
  input dats_pkg::in_word_t  in_word,
  input logic                out_strobe,
  input dats_pkg::out_word_t out_word
);
  import dats_pkg::*;

  // a result only shows once the sequencer is free again
  `DATS_ASSERT_NOW(a_strobe_idle, out_strobe, !busy)
  // an accepted add either answers at once or keeps the block busy
  `DATS_ASSERT_NEXT(a_accept_moves, start && !busy && in_word.command == CMD_ADD, busy || out_strobe)
  // a refused add hands out no id
  `DATS_ASSERT_NOW(a_full_no_id, out_strobe && out_word.status == STAT_FULL, out_word.result_id == 32'd0)
  // an empty pop carries no task
  `DATS_ASSERT_NOW(a_empty_no_task, out_strobe && out_word.status == STAT_EMPTY, out_word.result_id == 32'd0 && out_word.out_handle == 32'd0)

endmodule

bind dependency_aware_task_scheduler dats_checker u_dats_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .start      (start),
  .busy       (busy),
  .in_word    (in_word),
  .out_strobe (out_strobe),
  .out_word   (out_word)
);
